[sv/sacp_pkg.sv]
package sacp_pkg;

  // Default sizes for the frame buffer and for one decimal field.
  localparam int BufLenDef     = 10;
  localparam int FieldCharsDef = 5;

  // Depth of the queue between the framer and the parser.
  localparam int QueueDepth = 2;

  // Register reset values and indexes.
  localparam logic [15:0] TimeoutReset   = 16'd100;
  localparam logic [15:0] RackLimitReset = 16'd500;
  localparam logic        RegTimeout     = 1'b0;
  localparam logic        RegRackLimit   = 1'b1;

  // Characters of the framing and field syntax.
  localparam logic [7:0] CharOpen  = 8'h7B;  // '{'
  localparam logic [7:0] CharClose = 8'h7D;  // '}'
  localparam logic [7:0] CharAt    = 8'h40;  // '@'
  localparam logic [7:0] CharComma = 8'h2C;  // ','
  localparam logic [7:0] CharSpace = 8'h20;  // ' '
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharDig0  = 8'h30;  // '0'
  localparam logic [7:0] CharDig9  = 8'h39;  // '9'

  // Outcome flags of one result beat.
  typedef struct packed {
    logic address_set;
    logic rack_rejected;
    logic format_error;
  } sacp_flags_t;

  // Ten to the power n, evaluated at elaboration for value widths.
  function automatic longint pow10(input int n);
    longint r;
    r = 1;
    for (int k = 0; k < n; k++) begin
      r = r * 10;
    end
    return r;
  endfunction

endpackage

[sv/sacp_front.sv]
module sacp_front #(
  parameter int BufLen = sacp_pkg::BufLenDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  byte_present_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [15:0]           timeout_ticks_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic                  push_parse_o,
  output logic [BufLen*8-1:0]   snap_o
);

  localparam int FillW = $clog2(BufLen + 1);
  localparam int IdxW  = $clog2(BufLen);

  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhCapture = 2'd1;
  localparam logic [1:0] PhClosed  = 2'd2;

  logic [7:0]       buf_q [BufLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic [1:0]       phase_q, phase_d;
  logic [15:0]      ticks_q, ticks_d;
  logic             wr_en;
  logic             parse;
  logic [FillW-1:0] fill_t;
  logic [1:0]       phase_t;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Entries at or above the fill count read as zero, so a restart never
  // needs to clear the buffer itself.
  always_comb begin
    for (int i = 0; i < BufLen; i++) begin
      snap_o[i*8 +: 8] = (FillW'(i) < fill_q) ? buf_q[i] : sacp_pkg::CharNul;
    end
  end

  always_comb begin
    ticks_d = ticks_q;
    fill_t  = fill_q;
    phase_t = phase_q;
    if (ticks_q != 16'd0) begin
      ticks_d = ticks_q - 16'd1;
    end else begin
      fill_t  = '0;
      phase_t = PhIdle;
    end
    fill_d  = fill_t;
    phase_d = phase_t;
    wr_en   = 1'b0;
    parse   = 1'b0;
    if (byte_present_i) begin
      if (rx_byte_i == sacp_pkg::CharOpen) begin
        ticks_d = timeout_ticks_i;
        phase_d = PhCapture;
        fill_d  = '0;
      end else if (rx_byte_i == sacp_pkg::CharClose && phase_t == PhCapture) begin
        phase_d = PhClosed;
      end else if (rx_byte_i == sacp_pkg::CharAt && phase_t == PhClosed) begin
        parse = 1'b1;
      end else if (phase_t == PhCapture && fill_t < FillW'(BufLen)) begin
        wr_en  = 1'b1;
        fill_d = fill_t + FillW'(1);
      end
    end
  end

  assign push_parse_o = parse;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      phase_q <= PhIdle;
      ticks_q <= '0;
    end else if (push_o) begin
      fill_q  <= fill_d;
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o && wr_en) begin
      buf_q[fill_t[IdxW-1:0]] <= rx_byte_i;
    end
  end

endmodule

[sv/sacp_queue.sv]
module sacp_queue #(
  parameter int Width = 81
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             pop_i
);

  localparam int Depth = sacp_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[sv/sacp_back.sv]
module sacp_back #(
  parameter int BufLen     = sacp_pkg::BufLenDef,
  parameter int FieldChars = sacp_pkg::FieldCharsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic                  q_parse_i,
  input  logic [BufLen*8-1:0]   q_snap_i,
  output logic                  q_pop_o,
  input  logic [15:0]           rack_limit_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           area_id_o,
  output logic [15:0]           rack_id_o,
  output sacp_pkg::sacp_flags_t flags_o
);

  localparam int RawW = $clog2(sacp_pkg::pow10(FieldChars));
  localparam int ValW = (RawW > 16) ? RawW : 17;
  localparam int CntW = $clog2(BufLen);
  localparam int LenW = $clog2(FieldChars + 1);

  localparam logic [1:0] BkIdle = 2'd0;
  localparam logic [1:0] BkScan = 2'd1;
  localparam logic [1:0] BkDone = 2'd2;

  localparam logic [1:0] StSkip = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StStop = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [BufLen*8-1:0]   shreg_q, shreg_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  which_q, which_d;
  logic                  done_q, done_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [1:0]            stage_q, stage_d;
  logic [ValW-1:0]       area_v_q, area_v_d;
  logic [ValW-1:0]       rack_v_q, rack_v_d;
  logic                  bad_q, bad_d;
  logic [15:0]           area_q, area_d;
  logic [15:0]           rack_q, rack_d;
  logic                  out_valid_q, out_valid_d;
  sacp_pkg::sacp_flags_t flags_q, flags_d;
  logic                  out_free;
  logic [7:0]            ch;
  logic                  is_dig;
  logic [ValW-1:0]       cur_v;
  logic [ValW-1:0]       nxt_v;
  logic                  rack_over;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign area_id_o   = area_q;
  assign rack_id_o   = rack_q;
  assign flags_o     = flags_q;

  assign ch        = shreg_q[7:0];
  assign is_dig    = (ch >= sacp_pkg::CharDig0) && (ch <= sacp_pkg::CharDig9);
  assign cur_v     = which_q ? rack_v_q : area_v_q;
  assign rack_over = (rack_v_q >= {{(ValW-16){1'b0}}, rack_limit_i});

  always_comb begin
    state_d     = state_q;
    shreg_d     = shreg_q;
    cnt_d       = cnt_q;
    which_d     = which_q;
    done_d      = done_q;
    len_d       = len_q;
    stage_d     = stage_q;
    area_v_d    = area_v_q;
    rack_v_d    = rack_v_q;
    bad_d       = bad_q;
    area_d      = area_q;
    rack_d      = rack_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    nxt_v       = cur_v;

    case (state_q)
      BkIdle: begin
        if (q_valid_i && q_parse_i) begin
          q_pop_o  = 1'b1;
          shreg_d  = q_snap_i;
          cnt_d    = '0;
          which_d  = 1'b0;
          done_d   = 1'b0;
          len_d    = '0;
          stage_d  = StSkip;
          area_v_d = '0;
          rack_v_d = '0;
          bad_d    = 1'b0;
          state_d  = BkScan;
        end else if (q_valid_i && out_free) begin
          // Plain tick: repeat the stored ids with no flag raised.
          q_pop_o     = 1'b1;
          out_valid_d = 1'b1;
          flags_d     = '0;
        end
      end
      BkScan: begin
        // One buffer byte per cycle: legality, field split and the
        // running decimal value of the field it belongs to.
        if (!(is_dig || ch == sacp_pkg::CharComma || ch == sacp_pkg::CharSpace ||
              ch == sacp_pkg::CharNul)) begin
          bad_d = 1'b1;
        end
        if (!done_q) begin
          if (ch == sacp_pkg::CharComma) begin
            if (!which_q) begin
              which_d = 1'b1;
              len_d   = '0;
              stage_d = StSkip;
            end else begin
              done_d = 1'b1;
            end
          end else if (len_q < LenW'(FieldChars)) begin
            len_d = len_q + LenW'(1);
            case (stage_q)
              StSkip: begin
                if (is_dig) begin
                  nxt_v   = ValW'(ch[3:0]);
                  stage_d = StRead;
                end else if (ch != sacp_pkg::CharSpace) begin
                  stage_d = StStop;
                end
              end
              StRead: begin
                if (is_dig) begin
                  nxt_v = (cur_v << 3) + (cur_v << 1) + ValW'(ch[3:0]);
                end else begin
                  stage_d = StStop;
                end
              end
              default: begin
                stage_d = StStop;
              end
            endcase
            if (which_q) begin
              rack_v_d = nxt_v;
            end else begin
              area_v_d = nxt_v;
            end
          end
        end
        shreg_d = shreg_q >> 8;
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(BufLen - 1)) begin
          state_d = BkDone;
        end
      end
      BkDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          flags_d     = '0;
          if (bad_q) begin
            flags_d.format_error = 1'b1;
          end else if (rack_over) begin
            flags_d.rack_rejected = 1'b1;
            area_d = '0;
            rack_d = '0;
          end else begin
            flags_d.address_set = 1'b1;
            area_d = area_v_q[15:0];
            rack_d = rack_v_q[15:0];
          end
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
      area_q      <= '0;
      rack_q      <= '0;
      flags_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      area_q      <= area_d;
      rack_q      <= rack_d;
      flags_q     <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q  <= shreg_d;
    cnt_q    <= cnt_d;
    which_q  <= which_d;
    done_q   <= done_d;
    len_q    <= len_d;
    stage_q  <= stage_d;
    area_v_q <= area_v_d;
    rack_v_q <= rack_v_d;
    bad_q    <= bad_d;
  end

  // At most one outcome flag per result beat.
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0(flags_q))
    else $error("more than one outcome flag set");

  // A committed rack always lies below the configured limit.
  a_set_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && flags_q.address_set) |-> (rack_q < rack_limit_i))
    else $error("committed rack not below limit");

  // A rejected rack leaves both ids cleared.
  a_reject_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && flags_q.rack_rejected) |-> (area_q == 16'd0 && rack_q == 16'd0))
    else $error("rejected rack did not clear ids");

  // The queue is never drained while a parse is in progress.
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BkIdle) |-> !q_pop_o)
    else $error("queue popped during a parse");

endmodule

[sv/serial_address_command_parser_unit.sv]
// Path: a tick with no parse goes through its queue entry and then the result register;
// a tick that parses a frame goes through the queue entry, the scan and the done state.
// Throughput: one tick per cycle while no stall is raised, except that a parse holds the
// parser for a scan, one buffer byte per cycle; a two-entry queue absorbs ticks meanwhile.
// Reset (rst_ni low, asynchronous): idle framing, empty buffer, ids zero, no pending
// beats, timeout_ticks = 100 and rack_limit = 500.
module serial_address_command_parser_unit #(
  parameter int BUF_LEN     = sacp_pkg::BufLenDef,
  parameter int FIELD_CHARS = sacp_pkg::FieldCharsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        byte_present_i,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] area_id_o,
  output logic [15:0] rack_id_o,
  output logic        address_set_o,
  output logic        rack_rejected_o,
  output logic        format_error_o,
  // Register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int EntryW = 1 + BUF_LEN * 8;

  logic [15:0]           timeout_q;
  logic [15:0]           rack_limit_q;
  logic                  q_full;
  logic                  push;
  logic                  push_parse;
  logic [BUF_LEN*8-1:0]  snap;
  logic                  q_valid;
  logic [EntryW-1:0]     q_data;
  logic                  q_pop;
  sacp_pkg::sacp_flags_t flags;

  // Registers are always writable; the user must change them only while the block is idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= sacp_pkg::TimeoutReset;
      rack_limit_q <= sacp_pkg::RackLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sacp_pkg::RegTimeout:   timeout_q    <= cfg_data_i;
        sacp_pkg::RegRackLimit: rack_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The framer runs the tick timer and the capture phase; each accepted tick becomes one
  // queue entry with a buffer snapshot, flagged when a parse is requested.
  sacp_front #(
    .BufLen (BUF_LEN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .byte_present_i  (byte_present_i),
    .rx_byte_i       (rx_byte_i),
    .timeout_ticks_i (timeout_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_parse_o    (push_parse),
    .snap_o          (snap)
  );

  sacp_queue #(
    .Width (EntryW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_parse, snap}),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  // The parser keeps the ids and emits exactly one result beat per entry,
  // in queue order.
  sacp_back #(
    .BufLen     (BUF_LEN),
    .FieldChars (FIELD_CHARS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_parse_i    (q_data[EntryW-1]),
    .q_snap_i     (q_data[EntryW-2:0]),
    .q_pop_o      (q_pop),
    .rack_limit_i (rack_limit_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .area_id_o    (area_id_o),
    .rack_id_o    (rack_id_o),
    .flags_o      (flags)
  );

  assign address_set_o   = flags.address_set;
  assign rack_rejected_o = flags.rack_rejected;
  assign format_error_o  = flags.format_error;

endmodule

[tb/serial_address_command_parser_unit_tb.sv]
module serial_address_command_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sacp_pkg::*;

  localparam int BufLen     = BufLenDef;
  localparam int FieldChars = FieldCharsDef;

  // Watchdog limit in clock cycles. The slowest correct run (every tick a
  // parse that holds the parser for its whole buffer scan, with both sides
  // stalling) stays far below this.
  localparam int unsigned CycleLimit = 400000;

  // Framing phases of the predictor.
  typedef enum logic [1:0] {
    FrmIdle,
    FrmCapture,
    FrmClosed
  } frame_phase_e;

  // Outcome of parsing one closed frame.
  typedef enum logic [1:0] {
    ParseCommit,
    ParseRackHigh,
    ParseBadChar
  } parse_outcome_e;

  // One tick beat as it goes into the block.
  typedef struct packed {
    logic       present;
    logic [7:0] data;
  } tick_t;

  // One result beat as it comes out of the block.
  typedef struct packed {
    logic [15:0] area;
    logic [15:0] rack;
    sacp_flags_t flags;
  } addr_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        byte_present_i = 1'b0;
  logic [7:0]  rx_byte_i      = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [15:0] area_id_o;
  logic [15:0] rack_id_o;
  logic        address_set_o;
  logic        rack_rejected_o;
  logic        format_error_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i    = RegTimeout;
  logic [15:0] cfg_data_i     = 16'h0000;

  serial_address_command_parser_unit #(
    .BUF_LEN    (BufLen),
    .FIELD_CHARS(FieldChars)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_present_i (byte_present_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .area_id_o      (area_id_o),
    .rack_id_o      (rack_id_o),
    .address_set_o  (address_set_o),
    .rack_rejected_o(rack_rejected_o),
    .format_error_o (format_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Ticks waiting to be driven, and the address results that the block owes
  // for ticks it has already taken, oldest first.
  tick_t        pending_ticks[$];
  addr_result_t addr_due[$];

  // When set, neither side inserts gaps or stalls.
  bit          steady_run = 1'b0;
  int unsigned mismatches = 0;
  int unsigned ticks_queued;
  int unsigned cycle_count = 0;

  // Shadow of the block's registers and state, kept by the predictor.
  logic [15:0]                 timeout_cfg    = TimeoutReset;
  logic [15:0]                 rack_limit_cfg = RackLimitReset;
  logic [BufLen-1:0][7:0]      cap_buf        = '0;
  int unsigned                 cap_len        = 0;
  frame_phase_e                frm_state      = FrmIdle;
  logic [15:0]                 timer_left     = 16'd0;
  logic [15:0]                 area_now       = 16'd0;
  logic [15:0]                 rack_now       = 16'd0;

  function automatic logic is_digit(logic [7:0] c);
    return c >= CharDig0 && c <= CharDig9;
  endfunction

  // Reads one field the way atoi does: leading spaces skipped, then digits
  // up to the first non-digit.
  function automatic int unsigned field_value(logic [FieldChars-1:0][7:0] txt,
                                              int unsigned n);
    int unsigned k;
    int unsigned v;
    k = 0;
    v = 0;
    while (k < n && txt[k] == CharSpace) k++;
    while (k < n && is_digit(txt[k])) begin
      v = v * 10 + (txt[k] - CharDig0);
      k++;
    end
    return v;
  endfunction

  // Flags bad bytes, else splits area from rack and commits or rejects.
  function automatic parse_outcome_e decode_frame();
    logic [FieldChars-1:0][7:0] area_txt;
    logic [FieldChars-1:0][7:0] rack_txt;
    int unsigned                area_n;
    int unsigned                rack_n;
    int unsigned                area_v;
    int unsigned                rack_v;
    bit                         in_rack;
    bit                         stop;
    logic [7:0]                 c;
    for (int i = 0; i < BufLen; i++) begin
      c = cap_buf[i];
      if (!(is_digit(c) || c == CharComma || c == CharSpace || c == CharNul)) begin
        return ParseBadChar;
      end
    end
    area_txt = '0;
    rack_txt = '0;
    area_n   = 0;
    rack_n   = 0;
    in_rack  = 1'b0;
    stop     = 1'b0;
    for (int i = 0; i < BufLen && !stop; i++) begin
      c = cap_buf[i];
      if (c == CharComma) begin
        // A second comma ends the useful part of the frame.
        if (!in_rack) in_rack = 1'b1;
        else stop = 1'b1;
      end else if (!in_rack) begin
        if (area_n < FieldChars) begin
          area_txt[area_n] = c;
          area_n++;
        end
      end else if (rack_n < FieldChars) begin
        rack_txt[rack_n] = c;
        rack_n++;
      end
    end
    rack_v = field_value(rack_txt, rack_n);
    if (rack_v >= rack_limit_cfg) begin
      area_now = 16'd0;
      rack_now = 16'd0;
      return ParseRackHigh;
    end
    area_v   = field_value(area_txt, area_n);
    area_now = area_v[15:0];
    rack_now = rack_v[15:0];
    return ParseCommit;
  endfunction

  // Advances the shadow state by one tick and returns the expected beat.
  function automatic addr_result_t predict_tick(logic present, logic [7:0] rx);
    addr_result_t   r;
    parse_outcome_e how;
    r = '0;
    // The timer runs down first; on expiry the capture is abandoned before
    // this tick's byte is looked at.
    if (timer_left != 16'd0) begin
      timer_left = timer_left - 16'd1;
    end else begin
      cap_buf   = '0;
      cap_len   = 0;
      frm_state = FrmIdle;
    end
    if (present) begin
      if (rx == CharOpen) begin
        timer_left = timeout_cfg;
        frm_state  = FrmCapture;
        cap_buf    = '0;
        cap_len    = 0;
      end else if (rx == CharClose && frm_state == FrmCapture) begin
        frm_state = FrmClosed;
      end else if (rx == CharAt && frm_state == FrmClosed) begin
        how = decode_frame();
        case (how)
          ParseCommit:   r.flags.address_set   = 1'b1;
          ParseRackHigh: r.flags.rack_rejected = 1'b1;
          default:       r.flags.format_error  = 1'b1;
        endcase
      end else if (frm_state == FrmCapture && cap_len < BufLen) begin
        // An '@' during capture lands here and is stored like any byte.
        cap_buf[cap_len] = rx;
        cap_len++;
      end
    end
    r.area = area_now;
    r.rack = rack_now;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    end
  endfunction

  // Tick driver. The prediction is made at the edge that accepts a beat, so
  // it sees exactly the payload the block took. A stalled beat is held.
  always @(posedge clk_i or negedge rst_ni) begin
    tick_t nxt_tick;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        addr_due.push_back(predict_tick(byte_present_i, rx_byte_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ticks.size() != 0 && (steady_run || $urandom_range(99) >= 19)) begin
          nxt_tick = pending_ticks.pop_front();
          in_valid_i     <= 1'b1;
          byte_present_i <= nxt_tick.present;
          rx_byte_i      <= nxt_tick.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each accepted beat is matched against the oldest
  // expectation; the stall is redrawn every cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    addr_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (addr_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected beat: area %0d rack %0d flags %b%b%b", area_id_o, rack_id_o,
                     address_set_o, rack_rejected_o, format_error_o);
          end
        end else begin
          want = addr_due.pop_front();
          check_field("area_id", want.area, area_id_o);
          check_field("rack_id", want.rack, rack_id_o);
          check_field("address_set", want.flags.address_set, address_set_o);
          check_field("rack_rejected", want.flags.rack_rejected, rack_rejected_o);
          check_field("format_error", want.flags.format_error, format_error_o);
        end
      end
      out_stall_i <= !steady_run && ($urandom_range(99) < 19);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("serial_address_command_parser_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic push_tick(logic present, logic [7:0] data);
    pending_ticks.push_back('{present: present, data: data});
    ticks_queued++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_tick(1'b1, s[i]);
  endtask

  // Queues one character of a frame body, now and then replaced by an
  // arbitrary byte or preceded by an empty tick.
  task automatic push_body_char(logic [7:0] ch);
    if ($urandom_range(99) < 8) push_tick(1'b0, 8'($urandom_range(255)));
    if ($urandom_range(99) < 4) push_tick(1'b1, 8'($urandom_range(255)));
    else push_tick(1'b1, ch);
  endtask

  function automatic logic [7:0] soup_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return CharDig0 + 8'($urandom_range(9));
    if (r < 72) return CharComma;
    if (r < 82) return CharSpace;
    if (r < 86) return CharNul;
    if (r < 92) return CharAt;
    return 8'($urandom_range(255));
  endfunction

  // Queues one frame: mostly well-formed "{area,rack}@" with random content,
  // sometimes a broken one, sometimes plain line noise.
  task automatic queue_frame();
    int unsigned pick;
    int unsigned len;
    int          rack_v;
    string       body;
    pick = $urandom_range(99);
    if (pick < 80) begin
      push_tick(1'b1, CharOpen);
      if ($urandom_range(1) == 1) begin
        // Numeric body, often with the rack right at the limit.
        case ($urandom_range(2))
          0:       rack_v = int'(rack_limit_cfg) + $urandom_range(4) - 2;
          1:       rack_v = $urandom_range(int'(rack_limit_cfg));
          default: rack_v = $urandom_range(99999);
        endcase
        if (rack_v < 0) rack_v = 0;
        body = $sformatf("%0d,%0d", $urandom_range(99999), rack_v);
        if ($urandom_range(3) == 0) body = {" ", body};
        if ($urandom_range(5) == 0) body = {body, ",", $sformatf("%0d", $urandom_range(99))};
        for (int i = 0; i < body.len(); i++) push_body_char(body[i]);
      end else begin
        len = $urandom_range(13);
        for (int i = 0; i < len; i++) push_body_char(soup_char());
      end
      if ($urandom_range(99) < 90) push_tick(1'b1, CharClose);
      if ($urandom_range(99) < 6) begin
        // A long pause, enough to run out the shorter timeouts.
        len = $urandom_range(30, 1);
        for (int i = 0; i < len; i++) push_tick(1'b0, 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 90) push_tick(1'b1, CharAt);
      if ($urandom_range(99) < 20) push_tick(1'b1, CharAt);
    end else begin
      len = $urandom_range(5, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(5))
          0:       push_tick(1'b1, CharOpen);
          1:       push_tick(1'b1, CharClose);
          2:       push_tick(1'b1, CharAt);
          default: push_tick(1'($urandom_range(1)), 8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  task automatic queue_random(int unsigned n);
    ticks_queued = 0;
    while (ticks_queued < n) queue_frame();
  endtask

  // Waits until every queued tick was taken and every result came back.
  // Each tick yields exactly one beat, so the block is idle at that point.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid_i || addr_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes both registers back to back; valid stays high between the two
  // beats. The shadow copy changes at the edge that takes each beat.
  task automatic set_registers(logic [15:0] timeout_val, logic [15:0] limit_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegTimeout;
    cfg_data_i  <= timeout_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    timeout_cfg = timeout_val;
    cfg_index_i <= RegRackLimit;
    cfg_data_i  <= limit_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    rack_limit_cfg = limit_val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] timeout_val, logic [15:0] limit_val, int unsigned n);
    set_registers(timeout_val, limit_val);
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at the reset register values: ticks outside a frame
    // (empty, stray close, stray parse), a plain frame parsed twice, a frame
    // whose area needs more than 16 bits, and one whose third field is dropped.
    set_registers(TimeoutReset, RackLimitReset);
    ticks_queued = 0;
    push_tick(1'b0, 8'hFF);
    push_tick(1'b1, CharClose);
    push_tick(1'b1, CharAt);
    push_text("{12,34}@@");
    push_text("{99999,123}@");
    push_text("{7,8,9}@");
    queue_random(300);
    wait_drained();

    // Shortest nonzero timeout, widest rack range: frames rarely survive.
    run_phase(16'd1, 16'hFFFF, 150);
    // Longest timeout with a limit that only lets rack zero through.
    run_phase(16'hFFFF, 16'd1, 300);
    // Zero in both registers: capture drops at once and every rack fails.
    run_phase(16'd0, 16'd0, 100);

    // A stretch with no gaps and no stalls at all.
    steady_run = 1'b1;
    run_phase(16'($urandom_range(40, 5)), 16'($urandom_range(65535, 1)), 400);
    steady_run = 1'b0;

    run_phase(16'($urandom_range(20, 12)), 16'($urandom_range(1000, 100)), 300);

    // Let any stray beat surface before the verdict.
    repeat (BufLen + 4) @(posedge clk_i);
    if (mismatches == 0 && addr_due.size() == 0) begin
      $display("serial_address_command_parser_unit_tb OK");
    end else begin
      $display("serial_address_command_parser_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
